[hdl/antenna_tuner_binary_search_unit_macros.svh]
// Assertion helpers shared by the tuner RTL.
`ifndef ANTENNA_TUNER_BINARY_SEARCH_UNIT_MACROS_SVH
`define ANTENNA_TUNER_BINARY_SEARCH_UNIT_MACROS_SVH

// Check on every clock edge outside reset.
`define ATS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check on every clock edge, reset included.
`define ATS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/ats_pkg.sv]
package ats_pkg;

    localparam int SUM_BITS = 17;
    localparam logic [7:0] CODE_MAX = 8'd255;

    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic signed [9:0] code_t;

    // input kind (s_axis_tuser)
    localparam logic KIND_TUNE = 1'b0;
    localparam logic KIND_MEAS = 1'b1;

    typedef enum logic [1:0] {
        ST_RESET = 2'd0,
        ST_BUSY  = 2'd1,
        ST_PASS  = 2'd2,
        ST_FAIL  = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_IND     = 6'b000010,
        PH_CAP     = 6'b000100,
        PH_IND_EXT = 6'b001000,
        PH_CAP_EXT = 6'b010000,
        PH_CHECK   = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        PR_NONE  = 4'b0001,
        PR_LOW   = 4'b0010,
        PR_HIGH  = 4'b0100,
        PR_FINAL = 4'b1000
    } pend_t;

    // band edges in Hz and start ranges
    localparam logic [31:0] BAND_F0 = 32'd5000000;
    localparam logic [31:0] BAND_F1 = 32'd10000000;
    localparam logic [31:0] BAND_F2 = 32'd20000000;
    localparam logic [31:0] BAND_F3 = 32'd40000000;
    localparam logic [8:0]  RANGE_B0 = 9'd255;
    localparam logic [8:0]  RANGE_B1 = 9'd128;
    localparam logic [8:0]  RANGE_B2 = 9'd64;
    localparam logic [8:0]  RANGE_B3 = 9'd16;
    localparam logic [8:0]  RANGE_B4 = 9'd8;

    localparam logic [7:0] VSWR_RESET = 8'd0;
    localparam logic [15:0] VSWR_LIMIT_RESET = 16'd768;

    // s_axis_tdata layout
    localparam int IN_FREQ_LSB = 0;
    localparam int IN_FWD_LSB  = 32;
    localparam int IN_REV_LSB  = IN_FWD_LSB + SUM_BITS;
    localparam int IN_PTT_BIT  = IN_REV_LSB + SUM_BITS;
    localparam int IN_BITS     = IN_PTT_BIT + 1;
    localparam int IN_BYTES_W  = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS    = 20;
    localparam int OUT_BYTES_W = ((OUT_BITS + 7) / 8) * 8;

    function automatic logic [7:0] clamp_code(input logic [8:0] v);
        return (v > {1'b0, CODE_MAX}) ? CODE_MAX : v[7:0];
    endfunction

endpackage

[hdl/antenna_tuner_binary_search_unit.sv]
// Antenna tuner search controller. A tune transaction (tuser kind 0) picks a
// start range from the frequency, then the block bisects the inductor code
// and after it the signed capacitor code, widening a search while its result
// sits at the range limit, and finally asks for one check measurement that is
// judged against the VSWR limit. Every probe leaves as one result transaction
// with the relay pattern and measure_request set; the host answers with a
// measurement transaction (kind 1) carrying the forward and reverse sums.
// Frequency 0 clears all relays; PTT low ends a tune as failed. Tune requests
// during a tune and stray measurements are dropped without a result. Pipeline:
// one input register, combinational decision logic (two 17x17 cross products
// and a compare) and one result register; a transaction is taken every cycle
// while the result side keeps up, and its result goes from the input register
// to the result register. The VSWR limit register may only be written while idle.
module antenna_tuner_binary_search_unit
    import ats_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration: vswr_limit_q8
    input  logic                   cfg_wr_en,
    input  logic [15:0]            cfg_wr_data,
    // input: frequency_hz, forward_sum, reverse_sum, ptt_on (low bit up)
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  logic [0:0]             s_axis_tuser,
    // result: inductor_relays, capacitor_relays, measure_request, tune_state
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES_W-1:0] m_axis_tdata
);

    // configuration
    logic [15:0] vswr_limit_reg;

    // input register
    logic        in_vld_reg;
    logic        in_kind_reg;
    logic [31:0] in_freq_reg;
    sum_t        in_fwd_reg;
    sum_t        in_rev_reg;
    logic        in_ptt_reg;

    // search state
    logic [7:0] ind_reg, ind_next;
    logic [8:0] cap_reg, cap_next;
    status_t    status_reg, status_next;
    phase_t     phase_reg, phase_next;
    pend_t      pend_reg, pend_next;
    code_t      low_reg, low_next;
    code_t      high_reg, high_next;
    sum_t       lf_reg, lf_next, lr_reg, lr_next;
    sum_t       hf_reg, hf_next, hr_reg, hr_next;
    logic [7:0] rlim_reg, rlim_next;
    logic [7:0] clim_reg, clim_next;
    logic       opening_reg, opening_next;

    // result register
    logic                   out_vld_reg, out_vld_next;
    logic [OUT_BYTES_W-1:0] out_data_reg, out_data_next;

    logic fire;
    logic out_free;

    // decision helpers
    logic [7:0]            start_lim;
    logic [7:0]            rlim_grow, clim_grow;
    logic                  ind_ext_ok, cap_ext_ok;
    logic [2*SUM_BITS-1:0] prod_low, prod_high;
    logic [SUM_BITS:0]     chk_sum;
    sum_t                  chk_diff;
    logic [32:0]           chk_lhs, chk_rhs;
    logic                  chk_bad;
    code_t                 diff, half, neg_code;

    logic    ss_en;
    phase_t  ss_phase;
    code_t   ss_lo, ss_hi;
    logic    probe_en;
    code_t   probe_code;
    logic    fin_en;
    logic    emit, emit_req;
    status_t emit_st;

    // Advance the logic stage only when the result slot can take its output.
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign fire          = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // Start range from the band, clamped to the code range.
    always_comb begin
        if (in_freq_reg < BAND_F0) begin
            start_lim = clamp_code(RANGE_B0);
        end else if (in_freq_reg < BAND_F1) begin
            start_lim = clamp_code(RANGE_B1);
        end else if (in_freq_reg < BAND_F2) begin
            start_lim = clamp_code(RANGE_B2);
        end else if (in_freq_reg < BAND_F3) begin
            start_lim = clamp_code(RANGE_B3);
        end else begin
            start_lim = clamp_code(RANGE_B4);
        end
    end

    assign rlim_grow  = clamp_code({rlim_reg, 1'b0});
    assign clim_grow  = clamp_code({clim_reg, 1'b0});
    assign ind_ext_ok = (ind_reg == rlim_reg) && (rlim_reg < CODE_MAX);
    assign cap_ext_ok = (cap_reg[7:0] == clim_reg) && (clim_reg < CODE_MAX);

    // Cross products: the low end wins when rev_lo*fwd_hi < rev_hi*fwd_lo.
    // The fresh measurement replaces whichever end is pending.
    always_comb begin
        lf_next = lf_reg;
        lr_next = lr_reg;
        hf_next = hf_reg;
        hr_next = hr_reg;
        if (fire && in_kind_reg == KIND_MEAS && in_ptt_reg
                && phase_reg != PH_IDLE) begin
            if (pend_reg == PR_LOW) begin
                lf_next = in_fwd_reg;
                lr_next = in_rev_reg;
            end else if (pend_reg == PR_HIGH) begin
                hf_next = in_fwd_reg;
                hr_next = in_rev_reg;
            end
        end
    end

    assign prod_low  = lr_next * hf_next;
    assign prod_high = hr_next * lf_next;

    // Final VSWR check: fail when rev >= fwd or (fwd+rev)*256 > limit*(fwd-rev).
    assign chk_sum  = {1'b0, in_fwd_reg} + {1'b0, in_rev_reg};
    assign chk_diff = in_fwd_reg - in_rev_reg;
    assign chk_lhs  = {7'd0, chk_sum, 8'd0};
    assign chk_rhs  = vswr_limit_reg * chk_diff;
    assign chk_bad  = (in_rev_reg >= in_fwd_reg) || (chk_lhs > chk_rhs);

    assign diff = high_reg - low_reg;
    assign half = diff >>> 1;

    always_comb begin
        ind_next     = ind_reg;
        cap_next     = cap_reg;
        status_next  = status_reg;
        phase_next   = phase_reg;
        pend_next    = pend_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        rlim_next    = rlim_reg;
        clim_next    = clim_reg;
        opening_next = opening_reg;
        ss_en        = 1'b0;
        ss_phase     = PH_IDLE;
        ss_lo        = '0;
        ss_hi        = '0;
        probe_en     = 1'b0;
        probe_code   = '0;
        fin_en       = 1'b0;
        emit         = 1'b0;
        emit_req     = 1'b0;
        emit_st      = ST_RESET;
        neg_code     = '0;

        if (fire) begin
            if (in_kind_reg == KIND_TUNE) begin
                if (status_reg != ST_BUSY) begin
                    if (in_freq_reg == '0) begin
                        // clear all relays
                        ind_next     = '0;
                        cap_next     = '0;
                        status_next  = ST_RESET;
                        phase_next   = PH_IDLE;
                        pend_next    = PR_NONE;
                        opening_next = 1'b0;
                        emit         = 1'b1;
                        emit_st      = ST_RESET;
                    end else if (!in_ptt_reg) begin
                        status_next  = ST_FAIL;
                        phase_next   = PH_IDLE;
                        pend_next    = PR_NONE;
                        opening_next = 1'b0;
                        emit         = 1'b1;
                        emit_st      = ST_FAIL;
                    end else begin
                        rlim_next   = start_lim;
                        clim_next   = start_lim;
                        cap_next    = '0;
                        status_next = ST_BUSY;
                        ss_en       = 1'b1;
                        ss_phase    = PH_IND;
                        ss_lo       = '0;
                        ss_hi       = code_t'({2'b00, start_lim});
                    end
                end
            end else if (phase_reg != PH_IDLE && pend_reg != PR_NONE) begin
                if (!in_ptt_reg) begin
                    // keying dropped: stop where we are
                    status_next  = ST_FAIL;
                    phase_next   = PH_IDLE;
                    pend_next    = PR_NONE;
                    opening_next = 1'b0;
                    emit         = 1'b1;
                    emit_st      = ST_FAIL;
                end else if (pend_reg == PR_FINAL) begin
                    status_next  = chk_bad ? ST_FAIL : ST_PASS;
                    phase_next   = PH_IDLE;
                    pend_next    = PR_NONE;
                    opening_next = 1'b0;
                    emit         = 1'b1;
                    emit_st      = chk_bad ? ST_FAIL : ST_PASS;
                end else if (opening_reg) begin
                    // second end of a new search
                    opening_next = 1'b0;
                    pend_next    = PR_HIGH;
                    probe_en     = 1'b1;
                    probe_code   = high_reg;
                end else if (low_reg != high_reg) begin
                    if (prod_low < prod_high) begin
                        high_next  = low_reg + half;
                        pend_next  = PR_HIGH;
                        probe_en   = 1'b1;
                        probe_code = low_reg + half;
                    end else begin
                        low_next   = high_reg - half;
                        pend_next  = PR_LOW;
                        probe_en   = 1'b1;
                        probe_code = high_reg - half;
                    end
                end else begin
                    pend_next = PR_NONE;
                    fin_en    = 1'b1;
                end
            end
        end

        // Search converged: move to the next search or to the final check.
        if (fin_en) begin
            case (phase_reg)
                PH_IND: begin
                    ss_en    = 1'b1;
                    ss_phase = PH_CAP;
                    ss_lo    = -code_t'({2'b00, clim_reg});
                    ss_hi    = code_t'({2'b00, clim_reg});
                end
                default: begin
                    if (phase_reg != PH_CAP_EXT && ind_ext_ok) begin
                        rlim_next = rlim_grow;
                        ss_en     = 1'b1;
                        ss_phase  = PH_IND_EXT;
                        ss_lo     = code_t'({2'b00, rlim_reg});
                        ss_hi     = code_t'({2'b00, rlim_grow});
                    end else if (cap_ext_ok) begin
                        clim_next = clim_grow;
                        ss_en     = 1'b1;
                        ss_phase  = PH_CAP_EXT;
                        if (!cap_reg[8] && cap_reg[7:0] != '0) begin
                            ss_lo = code_t'({2'b00, clim_reg});
                            ss_hi = code_t'({2'b00, clim_grow});
                        end else begin
                            ss_lo = -code_t'({2'b00, clim_grow});
                            ss_hi = -code_t'({2'b00, clim_reg});
                        end
                    end else begin
                        phase_next = PH_CHECK;
                        pend_next  = PR_FINAL;
                        emit       = 1'b1;
                        emit_req   = 1'b1;
                        emit_st    = ST_BUSY;
                    end
                end
            endcase
        end

        if (ss_en) begin
            phase_next   = ss_phase;
            low_next     = ss_lo;
            high_next    = ss_hi;
            opening_next = 1'b1;
            pend_next    = PR_LOW;
            probe_en     = 1'b1;
            probe_code   = ss_lo;
        end

        // Drive the relays for the probed code and ask for a measurement.
        if (probe_en) begin
            neg_code = -probe_code;
            if (phase_next == PH_IND || phase_next == PH_IND_EXT) begin
                ind_next = probe_code[7:0];
            end else if (probe_code < 0) begin
                cap_next = {1'b1, neg_code[7:0]};
            end else begin
                cap_next = {1'b0, probe_code[7:0]};
            end
            emit     = 1'b1;
            emit_req = 1'b1;
            emit_st  = ST_BUSY;
        end
    end

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (out_free) begin
            out_vld_next = emit;
            if (emit) begin
                out_data_next = {(OUT_BYTES_W - OUT_BITS)'(0), emit_st, emit_req,
                                 cap_next, ind_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vswr_limit_reg <= VSWR_LIMIT_RESET;
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            ind_reg        <= VSWR_RESET;
            cap_reg        <= '0;
            status_reg     <= ST_RESET;
            phase_reg      <= PH_IDLE;
            pend_reg       <= PR_NONE;
            low_reg        <= '0;
            high_reg       <= '0;
            lf_reg         <= '0;
            lr_reg         <= '0;
            hf_reg         <= '0;
            hr_reg         <= '0;
            rlim_reg       <= '0;
            clim_reg       <= '0;
            opening_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                vswr_limit_reg <= cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            out_vld_reg <= out_vld_next;
            ind_reg     <= ind_next;
            cap_reg     <= cap_next;
            status_reg  <= status_next;
            phase_reg   <= phase_next;
            pend_reg    <= pend_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            lf_reg      <= lf_next;
            lr_reg      <= lr_next;
            hf_reg      <= hf_next;
            hr_reg      <= hr_next;
            rlim_reg    <= rlim_next;
            clim_reg    <= clim_next;
            opening_reg <= opening_next;
        end
    end

    // payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_kind_reg <= s_axis_tuser[0];
            in_freq_reg <= s_axis_tdata[IN_FREQ_LSB +: 32];
            in_fwd_reg  <= s_axis_tdata[IN_FWD_LSB +: SUM_BITS];
            in_rev_reg  <= s_axis_tdata[IN_REV_LSB +: SUM_BITS];
            in_ptt_reg  <= s_axis_tdata[IN_PTT_BIT];
        end
        out_data_reg <= out_data_next;
    end

    `include "antenna_tuner_binary_search_unit_macros.svh"

    `ATS_ASSERT(a_bounds_ordered, low_reg <= high_reg, "search bounds crossed")
    `ATS_ASSERT(a_idle_no_pending, (phase_reg == PH_IDLE) == (pend_reg == PR_NONE), "pending probe out of step with phase")
    `ATS_ASSERT(a_busy_matches_phase, (status_reg == ST_BUSY) == (phase_reg != PH_IDLE), "status out of step with phase")
    `ATS_ASSERT(a_request_while_busy, m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[19:18] == ST_BUSY, "measurement requested outside a tune")
    `ATS_ASSERT_ALWAYS(a_reset_no_result, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule
